>>> rtl/lmpf_pkg.sv
// lmpf_pkg: shared constants, types and fixed-point helpers for the lattice
// momentum phase factor core. No dependencies.
package lmpf_pkg;

    // default parameter values
    localparam int DEF_MAX_EXTENT    = 256;
    localparam int DEF_ANGLE_BITS    = 16;
    localparam int DEF_OUT_FRAC_BITS = 14;

    // magnitude width of mom * (coord + shift), |n| <= 128 * 510
    localparam int NMAG_W = 17;

    // Q30 constants
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // configuration register indexes
    localparam logic [2:0] REG_MOM_X    = 3'd0;
    localparam logic [2:0] REG_MOM_Y    = 3'd1;
    localparam logic [2:0] REG_MOM_Z    = 3'd2;
    localparam logic [2:0] REG_EXTENT_X = 3'd3;
    localparam logic [2:0] REG_EXTENT_Y = 3'd4;
    localparam logic [2:0] REG_EXTENT_Z = 3'd5;
    localparam logic [2:0] REG_TWISTED  = 3'd6;
    localparam logic [2:0] REG_COS_MODE = 3'd7;

    localparam logic [8:0] EXTENT_RESET = 9'd16;

    // taylor series divisors per round, sine and cosine
    localparam logic [5:0] SIN_DIV [3] = '{6'd42, 6'd20, 6'd6};
    localparam logic [5:0] COS_DIV [3] = '{6'd56, 6'd30, 6'd12};

    // floor(2^32 / divisor) reciprocals
    localparam logic [31:0] SIN_RCP [3] = '{
        32'(64'h1_0000_0000 / 64'd42),
        32'(64'h1_0000_0000 / 64'd20),
        32'(64'h1_0000_0000 / 64'd6)
    };
    localparam logic [31:0] COS_RCP [3] = '{
        32'(64'h1_0000_0000 / 64'd56),
        32'(64'h1_0000_0000 / 64'd30),
        32'(64'h1_0000_0000 / 64'd12)
    };

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } quad_t;

    // context carried down the sine/cosine pipeline
    typedef struct packed {
        logic [30:0] x;
        logic [30:0] x2;
        quad_t       quad;
        logic        swap;
    } sc_ctx_t;

    // (a * b) >> 30 on unsigned Q30 values up to 1.0
    function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
        logic [61:0] p;
        p = {31'b0, a} * {31'b0, b};
        return p[60:30];
    endfunction

    // reciprocal estimate, low by at most one
    function automatic logic [30:0] rcp_est(input logic [30:0] v, input logic [31:0] m);
        logic [62:0] p;
        p = {32'b0, v} * {31'b0, m};
        return p[62:32];
    endfunction

    // correct the estimate to the exact floor quotient
    function automatic logic [30:0] fix_quo(input logic [30:0] v, input logic [30:0] q0,
                                            input logic [5:0] c);
        logic [39:0] prod;
        logic [39:0] r;
        prod = {9'b0, q0} * {34'b0, c};
        r    = {9'b0, v} - prod;
        return (r >= {34'b0, c}) ? q0 + 31'd1 : q0;
    endfunction

endpackage

>>> rtl/lmpf_div_cell.sv
// lmpf_div_cell: one restoring division step, registered.
// Depends on nothing; quotient bits shift into the low end of the numerator.
module lmpf_div_cell #(
    parameter int REM_W = 10,
    parameter int NUM_W = 17
) (
    input  logic             clk,
    input  logic             en,
    input  logic [REM_W-1:0] divisor,
    input  logic [REM_W-1:0] rem_in,
    input  logic [NUM_W-1:0] num_in,
    output logic [REM_W-1:0] rem_out,
    output logic [NUM_W-1:0] num_out
);

    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             ge;
    logic [REM_W-1:0] rem_next;
    logic [NUM_W-1:0] num_next;
    logic [REM_W-1:0] rem_reg;
    logic [NUM_W-1:0] num_reg;

    // bring down one numerator bit, subtract when it fits
    always_comb
    begin
        trial    = {rem_in, num_in[NUM_W-1]};
        diff     = trial - {1'b0, divisor};
        ge       = (trial >= {1'b0, divisor});
        rem_next = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
        num_next = {num_in[NUM_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
        end
    end

    assign rem_out = rem_reg;
    assign num_out = num_reg;

endmodule

>>> rtl/lmpf_axis.sv
// lmpf_axis: per-axis angle lane, n = mom * (coord + shift), floor mod by the
// extent, then the rounded angle, both through chains of lmpf_div_cell.
module lmpf_axis import lmpf_pkg::*; #(
    parameter int MAX_EXTENT = DEF_MAX_EXTENT,
    parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [7:0]            mom,
    input  logic [8:0]            extent,
    input  logic                  twisted,
    input  logic [7:0]            coord,
    input  logic [8:0]            shift,
    output logic [ANGLE_BITS-1:0] angle
);

    localparam int EXT_W = $clog2(MAX_EXTENT + 1);
    localparam int D_W   = EXT_W + 1;
    localparam int NW    = D_W + ANGLE_BITS + 1;
    localparam int Q2_W  = ANGLE_BITS + 1;

    logic [31:0]        ext32;
    logic [31:0]        clamp32;
    logic [D_W-1:0]     divisor;
    logic signed [9:0]  pos;
    logic signed [17:0] n;
    logic [17:0]        nabs;
    logic [NMAG_W-1:0]  nmag_reg;
    logic               neg_reg;
    logic [D_W-1:0]     rem1 [NMAG_W];
    logic [NMAG_W-1:0]  num1 [NMAG_W];
    logic               negl_reg [NMAG_W];
    logic [D_W-1:0]     rem_last;
    logic [D_W-1:0]     m_reg;
    logic [NW-1:0]      n_full;
    logic [D_W-1:0]     rem2 [Q2_W];
    logic [Q2_W-1:0]    num2 [Q2_W];

    // phase denominator from the extent, clamped, doubled when twisted
    always_comb
    begin
        ext32   = {23'b0, extent};
        if (ext32 == 32'd0)
            clamp32 = 32'd1;
        else if (ext32 > 32'(MAX_EXTENT))
            clamp32 = 32'(MAX_EXTENT);
        else
            clamp32 = ext32;
        divisor = twisted ? D_W'(clamp32 << 1) : D_W'(clamp32);
    end

    // momentum times shifted position
    always_comb
    begin
        pos  = $signed({2'b00, coord}) + $signed({shift[8], shift});
        n    = $signed({{10{mom[7]}}, mom}) * $signed({{8{pos[9]}}, pos});
        nabs = n[17] ? 18'(-n) : 18'(n);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg <= nabs[NMAG_W-1:0];
            neg_reg  <= n[17];
        end
    end

    // |n| mod d, one bit per cell
    genvar i;
    generate
        for (i = 0; i < NMAG_W; i++)
        begin : g_mod
            if (i == 0)
            begin : g_first
                lmpf_div_cell #(.REM_W(D_W), .NUM_W(NMAG_W)) u_cell (
                    .clk     (clk),
                    .en      (en),
                    .divisor (divisor),
                    .rem_in  ('0),
                    .num_in  (nmag_reg),
                    .rem_out (rem1[i]),
                    .num_out (num1[i])
                );
                always_ff @(posedge clk)
                begin
                    if (en)
                        negl_reg[i] <= neg_reg;
                end
            end
            else
            begin : g_next
                lmpf_div_cell #(.REM_W(D_W), .NUM_W(NMAG_W)) u_cell (
                    .clk     (clk),
                    .en      (en),
                    .divisor (divisor),
                    .rem_in  (rem1[i-1]),
                    .num_in  (num1[i-1]),
                    .rem_out (rem1[i]),
                    .num_out (num1[i])
                );
                always_ff @(posedge clk)
                begin
                    if (en)
                        negl_reg[i] <= negl_reg[i-1];
                end
            end
        end
    endgenerate

    // floor modulo: a negative n with a remainder wraps to d - r
    assign rem_last = rem1[NMAG_W-1];

    always_ff @(posedge clk)
    begin
        if (en)
            m_reg <= (negl_reg[NMAG_W-1] && (rem_last != '0)) ? divisor - rem_last : rem_last;
    end

    // rounded angle: (m * 2^ANGLE_BITS + d/2) / d
    assign n_full = {1'b0, m_reg, {ANGLE_BITS{1'b0}}} + NW'(divisor >> 1);

    generate
        for (i = 0; i < Q2_W; i++)
        begin : g_ang
            if (i == 0)
            begin : g_first
                lmpf_div_cell #(.REM_W(D_W), .NUM_W(Q2_W)) u_cell (
                    .clk     (clk),
                    .en      (en),
                    .divisor (divisor),
                    .rem_in  (n_full[NW-1:ANGLE_BITS+1]),
                    .num_in  (n_full[ANGLE_BITS:0]),
                    .rem_out (rem2[i]),
                    .num_out (num2[i])
                );
            end
            else
            begin : g_next
                lmpf_div_cell #(.REM_W(D_W), .NUM_W(Q2_W)) u_cell (
                    .clk     (clk),
                    .en      (en),
                    .divisor (divisor),
                    .rem_in  (rem2[i-1]),
                    .num_in  (num2[i-1]),
                    .rem_out (rem2[i]),
                    .num_out (num2[i])
                );
            end
        end
    endgenerate

    // quotient wraps to zero modulo one turn
    assign angle = num2[Q2_W-1][ANGLE_BITS-1:0];

endmodule

>>> rtl/lmpf_sincos.sv
// lmpf_sincos: pipelined Q30 sine and cosine of an angle, octant reduction
// and nested taylor polynomials. Depends on lmpf_pkg.
module lmpf_sincos import lmpf_pkg::*; #(
    parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output logic signed [31:0]    cos_val,
    output logic signed [31:0]    sin_val
);

    localparam int R_W  = ANGLE_BITS - 2;
    localparam int PR_W = ANGLE_BITS + 30;
    localparam logic [R_W-1:0] HALF_OCT = R_W'(1) << (R_W - 1);
    localparam logic [R_W:0]   QTR      = (R_W + 1)'(1) << R_W;

    logic [R_W-1:0]  r;
    logic            swap;
    logic [R_W-1:0]  r2;
    logic [R_W:0]    r2w;
    logic [PR_W-1:0] xprod;
    sc_ctx_t         ctx_reg [1:13];
    logic [30:0]     vs_reg  [3];
    logic [30:0]     vc_reg  [3];
    logic [30:0]     vsd_reg [3];
    logic [30:0]     vcd_reg [3];
    logic [30:0]     qs_reg  [3];
    logic [30:0]     qc_reg  [3];
    logic [30:0]     ts_reg  [3];
    logic [30:0]     tc_reg  [3];
    logic [30:0]     sn12_reg;
    logic [30:0]     vc12_reg;
    logic [30:0]     sn13_reg;
    logic [30:0]     cs13_reg;
    logic [30:0]     sv;
    logic [30:0]     cv;
    logic signed [31:0] c_next;
    logic signed [31:0] s_next;
    logic signed [31:0] c_reg;
    logic signed [31:0] s_reg;

    // fold into the first octant and scale to radians
    always_comb
    begin
        r     = angle[R_W-1:0];
        swap  = (r > HALF_OCT);
        r2w   = swap ? QTR - {1'b0, r} : {1'b0, r};
        r2    = r2w[R_W-1:0];
        xprod = {(PR_W-R_W)'(0), r2} * {(PR_W-32)'(0), PI_Q30};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[1].x    <= xprod[PR_W-1:ANGLE_BITS-1];
            ctx_reg[1].x2   <= '0;
            ctx_reg[1].quad <= quad_t'(angle[ANGLE_BITS-1:ANGLE_BITS-2]);
            ctx_reg[1].swap <= swap;
        end
    end

    // x squared
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg[2].x    <= ctx_reg[1].x;
            ctx_reg[2].x2   <= mul_q30(ctx_reg[1].x, ctx_reg[1].x);
            ctx_reg[2].quad <= ctx_reg[1].quad;
            ctx_reg[2].swap <= ctx_reg[1].swap;
        end
    end

    genvar s;
    generate
        for (s = 3; s <= 13; s++)
        begin : g_ctx
            always_ff @(posedge clk)
            begin
                if (en)
                    ctx_reg[s] <= ctx_reg[s-1];
            end
        end
    endgenerate

    // three polynomial rounds: t = 1 - (x2 * t) / k, three stages each
    genvar k;
    generate
        for (k = 0; k < 3; k++)
        begin : g_round
            if (k == 0)
            begin : g_first
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        vs_reg[k] <= ctx_reg[2].x2;
                        vc_reg[k] <= ctx_reg[2].x2;
                    end
                end
            end
            else
            begin : g_next
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        vs_reg[k] <= mul_q30(ctx_reg[2+3*k].x2, ts_reg[k-1]);
                        vc_reg[k] <= mul_q30(ctx_reg[2+3*k].x2, tc_reg[k-1]);
                    end
                end
            end

            // reciprocal estimate, then exact correction
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    qs_reg[k]  <= rcp_est(vs_reg[k], SIN_RCP[k]);
                    qc_reg[k]  <= rcp_est(vc_reg[k], COS_RCP[k]);
                    vsd_reg[k] <= vs_reg[k];
                    vcd_reg[k] <= vc_reg[k];
                    ts_reg[k]  <= ONE_Q30 - fix_quo(vsd_reg[k], qs_reg[k], SIN_DIV[k]);
                    tc_reg[k]  <= ONE_Q30 - fix_quo(vcd_reg[k], qc_reg[k], COS_DIV[k]);
                end
            end
        end
    endgenerate

    // last terms: sin = x * t, cos = 1 - x2 * t / 2
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sn12_reg <= mul_q30(ctx_reg[11].x, ts_reg[2]);
            vc12_reg <= mul_q30(ctx_reg[11].x2, tc_reg[2]);
            sn13_reg <= sn12_reg;
            cs13_reg <= ONE_Q30 - {1'b0, vc12_reg[30:1]};
        end
    end

    // undo octant fold and place in the quadrant
    always_comb
    begin
        sv = ctx_reg[13].swap ? cs13_reg : sn13_reg;
        cv = ctx_reg[13].swap ? sn13_reg : cs13_reg;
        case (ctx_reg[13].quad)
            QUAD_0:
            begin
                c_next = $signed({1'b0, cv});
                s_next = $signed({1'b0, sv});
            end
            QUAD_1:
            begin
                c_next = -$signed({1'b0, sv});
                s_next = $signed({1'b0, cv});
            end
            QUAD_2:
            begin
                c_next = -$signed({1'b0, cv});
                s_next = -$signed({1'b0, sv});
            end
            QUAD_3:
            begin
                c_next = $signed({1'b0, sv});
                s_next = -$signed({1'b0, cv});
            end
            default:
            begin
                c_next = $signed({1'b0, cv});
                s_next = $signed({1'b0, sv});
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= c_next;
            s_reg <= s_next;
        end
    end

    assign cos_val = c_reg;
    assign sin_val = s_reg;

endmodule

>>> rtl/lattice_momentum_phase_factor_core.sv
// lattice_momentum_phase_factor_core: top level, config registers, three axis
// lanes, sine/cosine units, product stages and output register.
// Depends on lmpf_pkg, lmpf_axis, lmpf_sincos (and lmpf_div_cell below them).

// Computes the momentum phase factor of each lattice site: a site item
// accepted on the site channel gives one Q2.14 result item on the result
// channel, through the per-axis chains of division cells (17 for the modulo,
// ANGLE_BITS + 1 for the angle), the 14-stage sine/cosine pipeline and the
// two product stages. A new site is taken every cycle while site_stall is low;
// a stalled result holds the output register, and the whole pipeline once its
// last stage holds an item. The user must write configuration over the APB
// port only while no item is in flight; the block itself does not enforce it.
module lattice_momentum_phase_factor_core import lmpf_pkg::*; #(
    parameter int MAX_EXTENT    = DEF_MAX_EXTENT,
    parameter int ANGLE_BITS    = DEF_ANGLE_BITS,
    parameter int OUT_FRAC_BITS = DEF_OUT_FRAC_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        site_valid,
    output logic        site_stall,
    input  logic [7:0]  coord_x,
    input  logic [7:0]  coord_y,
    input  logic [7:0]  coord_z,
    input  logic signed [8:0] shift_x,
    input  logic signed [8:0] shift_y,
    input  logic signed [8:0] shift_z,
    output logic        result_valid,
    input  logic        result_stall,
    output logic signed [15:0] real_part,
    output logic signed [15:0] imag_part
);

    localparam int LANE_D = ANGLE_BITS + 20;
    localparam int DEPTH  = LANE_D + 1 + 14 + 2;
    localparam int SH     = 30 - OUT_FRAC_BITS;
    localparam logic [31:0] RND_HALF = (SH > 0) ? (32'd1 << (SH - 1)) : 32'd0;
    localparam logic [31:0] ONE_OUT  = 32'd1 << OUT_FRAC_BITS;

    logic [7:0] mom_x_reg;
    logic [7:0] mom_y_reg;
    logic [7:0] mom_z_reg;
    logic [8:0] extent_x_reg;
    logic [8:0] extent_y_reg;
    logic [8:0] extent_z_reg;
    logic       twisted_reg;
    logic       cos_mode_reg;
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    logic             adv;
    logic             load_out;
    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;

    logic [ANGLE_BITS-1:0] ax;
    logic [ANGLE_BITS-1:0] ay;
    logic [ANGLE_BITS-1:0] az;
    logic [ANGLE_BITS-1:0] ang0_reg;
    logic [ANGLE_BITS-1:0] ang1_reg;
    logic [ANGLE_BITS-1:0] ang2_reg;

    logic signed [31:0] cx;
    logic signed [31:0] sx;
    logic signed [31:0] cy;
    logic signed [31:0] sy;
    logic signed [31:0] cz;
    logic signed [31:0] sz;

    logic [31:0] acx;
    logic [31:0] acy;
    logic [31:0] acz;
    logic [61:0] p1;
    logic [61:0] p2;
    logic [30:0] m1_reg;
    logic        neg1_reg;
    logic [30:0] acz_reg;
    logic        negz_reg;
    logic signed [31:0] ce1_reg;
    logic signed [31:0] se1_reg;
    logic [30:0] u2_reg;
    logic        neg2_reg;
    logic signed [31:0] ce2_reg;
    logic signed [31:0] se2_reg;
    logic signed [31:0] cos_prod;

    logic        result_valid_reg;
    logic [15:0] real_next;
    logic [15:0] imag_next;
    logic [15:0] real_reg;
    logic [15:0] imag_reg;

    // configuration registers
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mom_x_reg    <= '0;
            mom_y_reg    <= '0;
            mom_z_reg    <= '0;
            extent_x_reg <= EXTENT_RESET;
            extent_y_reg <= EXTENT_RESET;
            extent_z_reg <= EXTENT_RESET;
            twisted_reg  <= 1'b0;
            cos_mode_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_MOM_X:    mom_x_reg    <= pwdata[7:0];
                REG_MOM_Y:    mom_y_reg    <= pwdata[7:0];
                REG_MOM_Z:    mom_z_reg    <= pwdata[7:0];
                REG_EXTENT_X: extent_x_reg <= pwdata[8:0];
                REG_EXTENT_Y: extent_y_reg <= pwdata[8:0];
                REG_EXTENT_Z: extent_z_reg <= pwdata[8:0];
                REG_TWISTED:  twisted_reg  <= pwdata[0];
                REG_COS_MODE: cos_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (cfg_idx)
            REG_MOM_X:    prdata = {24'b0, mom_x_reg};
            REG_MOM_Y:    prdata = {24'b0, mom_y_reg};
            REG_MOM_Z:    prdata = {24'b0, mom_z_reg};
            REG_EXTENT_X: prdata = {23'b0, extent_x_reg};
            REG_EXTENT_Y: prdata = {23'b0, extent_y_reg};
            REG_EXTENT_Z: prdata = {23'b0, extent_z_reg};
            REG_TWISTED:  prdata = {31'b0, twisted_reg};
            REG_COS_MODE: prdata = {31'b0, cos_mode_reg};
            default:      prdata = 32'b0;
        endcase
    end

    // pipeline advances unless a held result would be overwritten
    assign load_out   = !result_valid_reg || !result_stall;
    assign adv        = load_out || !vld_reg[DEPTH-1];
    assign site_stall = !adv;
    assign vld_next   = {vld_reg[DEPTH-2:0], site_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // per-axis angle lanes
    lmpf_axis #(.MAX_EXTENT(MAX_EXTENT), .ANGLE_BITS(ANGLE_BITS)) u_axis_x (
        .clk     (clk),
        .en      (adv),
        .mom     (mom_x_reg),
        .extent  (extent_x_reg),
        .twisted (twisted_reg),
        .coord   (coord_x),
        .shift   (shift_x),
        .angle   (ax)
    );

    lmpf_axis #(.MAX_EXTENT(MAX_EXTENT), .ANGLE_BITS(ANGLE_BITS)) u_axis_y (
        .clk     (clk),
        .en      (adv),
        .mom     (mom_y_reg),
        .extent  (extent_y_reg),
        .twisted (twisted_reg),
        .coord   (coord_y),
        .shift   (shift_y),
        .angle   (ay)
    );

    lmpf_axis #(.MAX_EXTENT(MAX_EXTENT), .ANGLE_BITS(ANGLE_BITS)) u_axis_z (
        .clk     (clk),
        .en      (adv),
        .mom     (mom_z_reg),
        .extent  (extent_z_reg),
        .twisted (twisted_reg),
        .coord   (coord_z),
        .shift   (shift_z),
        .angle   (az)
    );

    // total angle in exponential mode, separate angles in cosine mode
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ang0_reg <= cos_mode_reg ? ax : ax + ay + az;
            ang1_reg <= ay;
            ang2_reg <= az;
        end
    end

    lmpf_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc0 (
        .clk     (clk),
        .en      (adv),
        .angle   (ang0_reg),
        .cos_val (cx),
        .sin_val (sx)
    );

    lmpf_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc1 (
        .clk     (clk),
        .en      (adv),
        .angle   (ang1_reg),
        .cos_val (cy),
        .sin_val (sy)
    );

    lmpf_sincos #(.ANGLE_BITS(ANGLE_BITS)) u_sc2 (
        .clk     (clk),
        .en      (adv),
        .angle   (ang2_reg),
        .cos_val (cz),
        .sin_val (sz)
    );

    // cosine product, magnitudes rounded half up, sign tracked apart
    always_comb
    begin
        acx = cx[31] ? 32'(-cx) : 32'(cx);
        acy = cy[31] ? 32'(-cy) : 32'(cy);
        acz = cz[31] ? 32'(-cz) : 32'(cz);
        p1  = {31'b0, acx[30:0]} * {31'b0, acy[30:0]} + (62'd1 << 29);
        p2  = {31'b0, m1_reg} * {31'b0, acz_reg} + (62'd1 << 29);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_reg   <= p1[60:30];
            neg1_reg <= cx[31] ^ cy[31];
            acz_reg  <= acz[30:0];
            negz_reg <= cz[31];
            ce1_reg  <= cx;
            se1_reg  <= sx;
            u2_reg   <= p2[60:30];
            neg2_reg <= neg1_reg ^ negz_reg;
            ce2_reg  <= ce1_reg;
            se2_reg  <= se1_reg;
        end
    end

    // Q30 to output format, rounding the magnitude half away from zero
    function automatic logic [15:0] to_out(input logic signed [31:0] v);
        logic [31:0] mag;
        logic [31:0] rnd;
        mag = v[31] ? 32'(-v) : 32'(v);
        rnd = (mag + RND_HALF) >> SH;
        return v[31] ? 16'(-rnd) : rnd[15:0];
    endfunction

    assign cos_prod = neg2_reg ? -$signed({1'b0, u2_reg}) : $signed({1'b0, u2_reg});

    // zero momentum forces exactly one
    always_comb
    begin
        if ((mom_x_reg == '0) && (mom_y_reg == '0) && (mom_z_reg == '0))
        begin
            real_next = ONE_OUT[15:0];
            imag_next = '0;
        end
        else if (cos_mode_reg)
        begin
            real_next = to_out(cos_prod);
            imag_next = '0;
        end
        else
        begin
            real_next = to_out(ce2_reg);
            imag_next = to_out(-se2_reg);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (load_out)
            result_valid_reg <= vld_reg[DEPTH-1];
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            real_reg <= real_next;
            imag_reg <= imag_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign real_part    = $signed(real_reg);
    assign imag_part    = $signed(imag_reg);

endmodule
